// ===== design/xoro_pkg.sv =====
// shared types and constants for the xoroshiro128+ generator
package xoro_pkg;

   localparam int unsigned WORD_W = 64;
   localparam int unsigned HALF_W = 32;
   localparam int unsigned WARM_W = 16;

   localparam logic [WARM_W-1:0] WARMUP_STEPS = 16'd1000;

   localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
   localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
   localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d049bb133111eb;

   localparam logic ACT_GENERATE = 1'b0;
   localparam logic ACT_RESEED   = 1'b1;

   typedef enum logic [4:0] {
      S_BOOT,
      S_IDLE,
      S_ADD,
      S_MIX30,
      S_M1_LL,
      S_M1_HL,
      S_M1_LH,
      S_M1_END,
      S_MIX27,
      S_M2_LL,
      S_M2_HL,
      S_M2_LH,
      S_M2_END,
      S_STORE,
      S_WARM
   } ctrl_state_type;

   typedef enum logic [2:0] {
      Z_HOLD,
      Z_ADD_GAMMA,
      Z_MIX30,
      Z_MIX27,
      Z_MUL_LL,
      Z_MUL_HL,
      Z_MUL_LH,
      Z_MUL_END
   } z_op_type;

   typedef struct packed {
      logic     load_seed;
      logic     seed_zero;
      z_op_type z_op;
      logic     k_sel;
      logic     store_a;
      logic     store_b;
      logic     advance;
      logic     capture;
   } dp_cmd_type;

endpackage

// ===== design/xoro_dp.sv =====
// datapath: state words, splitmix64 unit with shared 32x32 multiplier, result register
module xoro_dp import xoro_pkg::*; (
   input  logic              clock,
   input  dp_cmd_type        cmd,
   input  logic [WORD_W-1:0] seed_value,
   output logic [WORD_W-1:0] random_value
);

   logic [WORD_W-1:0] a_ff, a_in;
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] ctr_ff, ctr_in;
   logic [WORD_W-1:0] z_ff, z_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] mul_ff, mul_in;
   logic [WORD_W-1:0] rsp_ff;

   logic [WORD_W-1:0] k_word;
   logic [HALF_W-1:0] mul_x, mul_y;
   logic [WORD_W-1:0] mul_p;
   logic [WORD_W-1:0] ctr_next;
   logic [WORD_W-1:0] mul_shift;
   logic [WORD_W-1:0] sm_out;
   logic [WORD_W-1:0] bx;
   logic [WORD_W-1:0] a_step, b_step;

   assign k_word    = cmd.k_sel ? SM_MUL2 : SM_MUL1;
   assign ctr_next  = ctr_ff + SM_GAMMA;
   assign mul_shift = {mul_ff[HALF_W-1:0], {HALF_W{1'b0}}};
   assign sm_out    = z_ff ^ (z_ff >> 31);

   // one xoroshiro128+ step
   assign bx     = b_ff ^ a_ff;
   assign a_step = {a_ff[8:0], a_ff[63:9]} ^ bx ^ (bx << 14);
   assign b_step = {bx[27:0], bx[63:28]};

   // low 64 bits of z * k from three partial products
   always_comb begin
      mul_x = z_ff[HALF_W-1:0];
      mul_y = k_word[HALF_W-1:0];
      case (cmd.z_op)
         Z_MUL_HL: begin
            mul_x = z_ff[WORD_W-1:HALF_W];
         end
         Z_MUL_LH: begin
            mul_y = k_word[WORD_W-1:HALF_W];
         end
         default: begin
         end
      endcase
   end

   assign mul_p = WORD_W'(mul_x) * WORD_W'(mul_y);

   always_comb begin
      ctr_in = ctr_ff;
      z_in   = z_ff;
      acc_in = acc_ff;
      mul_in = mul_ff;
      case (cmd.z_op)
         Z_HOLD: begin
         end
         Z_ADD_GAMMA: begin
            ctr_in = ctr_next;
            z_in   = ctr_next;
         end
         Z_MIX30: begin
            z_in = z_ff ^ (z_ff >> 30);
         end
         Z_MIX27: begin
            z_in = z_ff ^ (z_ff >> 27);
         end
         Z_MUL_LL: begin
            mul_in = mul_p;
         end
         Z_MUL_HL: begin
            acc_in = mul_ff;
            mul_in = mul_p;
         end
         Z_MUL_LH: begin
            acc_in = acc_ff + mul_shift;
            mul_in = mul_p;
         end
         Z_MUL_END: begin
            z_in = acc_ff + mul_shift;
         end
         default: begin
         end
      endcase
      if (cmd.load_seed) begin
         ctr_in = cmd.seed_zero ? '0 : seed_value;
      end
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (cmd.advance) begin
         a_in = a_step;
         b_in = b_step;
      end
      if (cmd.store_a) begin
         a_in = sm_out;
      end
      if (cmd.store_b) begin
         b_in = sm_out;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      ctr_ff <= ctr_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      mul_ff <= mul_in;
      if (cmd.capture) begin
         rsp_ff <= a_ff + b_ff;
      end
   end

   assign random_value = rsp_ff;

endmodule

// ===== design/xoro_ctrl.sv =====
// controller: handshakes, seeding sequence and warm-up counter
module xoro_ctrl import xoro_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_action,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   ctrl_state_type    state_ff, state_in;
   logic              word_ff, word_in;
   logic [WARM_W-1:0] warm_ff, warm_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_take;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_BOOT;
         word_ff      <= 1'b0;
         warm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         warm_ff      <= warm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      warm_in       = warm_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.z_op      = Z_HOLD;
      case (state_ff)
         S_BOOT: begin
            cmd.load_seed = 1'b1;
            cmd.seed_zero = 1'b1;
            word_in       = 1'b0;
            state_in      = S_ADD;
         end
         S_IDLE: begin
            if (req_take) begin
               case (req_action)
                  ACT_GENERATE: begin
                     cmd.capture  = 1'b1;
                     cmd.advance  = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_RESEED: begin
                     cmd.load_seed = 1'b1;
                     word_in       = 1'b0;
                     state_in      = S_ADD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD: begin
            cmd.z_op = Z_ADD_GAMMA;
            state_in = S_MIX30;
         end
         S_MIX30: begin
            cmd.z_op = Z_MIX30;
            state_in = S_M1_LL;
         end
         S_M1_LL: begin
            cmd.z_op = Z_MUL_LL;
            state_in = S_M1_HL;
         end
         S_M1_HL: begin
            cmd.z_op = Z_MUL_HL;
            state_in = S_M1_LH;
         end
         S_M1_LH: begin
            cmd.z_op = Z_MUL_LH;
            state_in = S_M1_END;
         end
         S_M1_END: begin
            cmd.z_op = Z_MUL_END;
            state_in = S_MIX27;
         end
         S_MIX27: begin
            cmd.z_op = Z_MIX27;
            state_in = S_M2_LL;
         end
         S_M2_LL: begin
            cmd.z_op  = Z_MUL_LL;
            cmd.k_sel = 1'b1;
            state_in  = S_M2_HL;
         end
         S_M2_HL: begin
            cmd.z_op  = Z_MUL_HL;
            cmd.k_sel = 1'b1;
            state_in  = S_M2_LH;
         end
         S_M2_LH: begin
            cmd.z_op  = Z_MUL_LH;
            cmd.k_sel = 1'b1;
            state_in  = S_M2_END;
         end
         S_M2_END: begin
            cmd.z_op  = Z_MUL_END;
            cmd.k_sel = 1'b1;
            state_in  = S_STORE;
         end
         S_STORE: begin
            if (!word_ff) begin
               cmd.store_a = 1'b1;
               word_in     = 1'b1;
               state_in    = S_ADD;
            end else begin
               cmd.store_b = 1'b1;
               warm_in     = WARMUP_STEPS;
               state_in    = (WARMUP_STEPS == '0) ? S_IDLE : S_WARM;
            end
         end
         S_WARM: begin
            cmd.advance = 1'b1;
            warm_in     = warm_ff - WARM_W'(1);
            if (warm_ff == WARM_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_BOOT;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/xoroshiro128_plus_prng.sv =====
// top level of the xoroshiro128+ generator with splitmix64 seeding
//
//  channel   ports                                  direction
//  request   req_valid req_stall req_action         in  (req_stall out)
//            req_seed_value
//  response  rsp_valid rsp_stall rsp_random_value   out (rsp_stall in)
//
// back-to-back generates give one number per cycle while the receiver does not hold rsp_stall
// a reseed request loads the seed, runs splitmix64 for two words (each 12 controller
// states, S_ADD to S_STORE, on the shared 32x32 multiplier) and then WARMUP_STEPS
// warm-up steps of the generator
// after reset the block seeds itself from seed zero the same way before
// it takes a request
// a pending response sits in the output register; requests stall only while it is
// held by rsp_stall or while seeding or warm-up runs
module xoroshiro128_plus_prng import xoro_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [WORD_W-1:0] req_seed_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_random_value
);

   dp_cmd_type cmd;

   xoro_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd)
   );

   xoro_dp u_dp (
      .clock        (clock),
      .cmd          (cmd),
      .seed_value   (req_seed_value),
      .random_value (rsp_random_value)
   );

endmodule

// ===== tb/tb_xoroshiro128_plus_prng.sv =====
// testbench for the xoroshiro128+ generator: random number and reseed requests checked in order
module tb_xoroshiro128_plus_prng;
   import xoro_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 1100;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = ACT_GENERATE;
   logic [WORD_W-1:0] req_seed_value = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [WORD_W-1:0] rsp_random_value;

   // generator state as the block should hold it
   logic [WORD_W-1:0] gen_word_a;
   logic [WORD_W-1:0] gen_word_b;
   logic [WORD_W-1:0] mix_counter;

   logic [WORD_W-1:0] expected_numbers[$];
   logic [WORD_W-1:0] wanted_number;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   long_hold_len = 0;
   logic hold_active = 1'b0;
   event hold_start;
   int   mismatch_count = 0;
   int   cycle_count = 0;

   xoroshiro128_plus_prng dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_seed_value   (req_seed_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

   always #CLK_HALF clock = ~clock;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int k);
      return (v << k) | (v >> (WORD_W - k));
   endfunction

   function automatic logic [WORD_W-1:0] splitmix_next();
      logic [WORD_W-1:0] z;
      mix_counter = mix_counter + SM_GAMMA;
      z = mix_counter;
      z = (z ^ (z >> 30)) * SM_MUL1;
      z = (z ^ (z >> 27)) * SM_MUL2;
      return z ^ (z >> 31);
   endfunction

   // returns the number for the current state, then steps the state
   function automatic logic [WORD_W-1:0] step_generator();
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] sum;
      a = gen_word_a;
      b = gen_word_b;
      sum = a + b;
      b = b ^ a;
      gen_word_a = rotl(a, 55) ^ b ^ (b << 14);
      gen_word_b = rotl(b, 36);
      return sum;
   endfunction

   function automatic void reseed_generator(input logic [WORD_W-1:0] seed);
      mix_counter = seed;
      gen_word_a = splitmix_next();
      gen_word_b = splitmix_next();
      for (int i = 0; i < int'(WARMUP_STEPS); i++) begin
         void'(step_generator());
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // drives one request and returns at the edge that takes it, valid still high
   task automatic send_request(input logic act, input logic [WORD_W-1:0] seed);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_seed_value <= seed;
      do @(posedge clock); while (req_stall);
      if (act == ACT_RESEED) begin
         reseed_generator(seed);
      end else begin
         expected_numbers.push_back(step_generator());
      end
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(hold_start);
      hold_active <= 1'b1;
      repeat (long_hold_len) @(posedge clock);
      hold_active <= 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= hold_active || ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_numbers.size() == 0) begin
            report_mismatch($sformatf("number %h with nothing expected", rsp_random_value));
         end else begin
            wanted_number = expected_numbers.pop_front();
            if (rsp_random_value !== wanted_number) begin
               report_mismatch($sformatf("random_value %h, wanted %h",
                                         rsp_random_value, wanted_number));
            end
         end
      end
   end

   // first numbers come from the self-seeding with seed zero
   task automatic test_boot_state();
      for (int i = 0; i < 4; i++) begin
         send_request(ACT_GENERATE, random_word());
      end
   endtask

   task automatic test_seed_extremes();
      send_request(ACT_RESEED, '0);
      send_request(ACT_GENERATE, '1);
      send_request(ACT_GENERATE, '0);
      send_request(ACT_RESEED, '1);
      send_request(ACT_GENERATE, '1);
      send_request(ACT_GENERATE, 64'h5555_5555_5555_5555);
      send_request(ACT_RESEED, 64'd1);
      send_request(ACT_GENERATE, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(ACT_RESEED, 64'h8000_0000_0000_0000);
      send_request(ACT_GENERATE, '0);
      send_request(ACT_RESEED, 64'haaaa_aaaa_aaaa_aaaa);
      send_request(ACT_GENERATE, '0);
      // back-to-back reseeds, the second one wins
      send_request(ACT_RESEED, 64'h5555_5555_5555_5555);
      send_request(ACT_RESEED, 64'hdead_beef_0123_4567);
      send_request(ACT_GENERATE, '1);
      send_request(ACT_GENERATE, '0);
   endtask

   task automatic test_mixed_traffic(input int count, input int idle_pct, input int hold_pct);
      logic [WORD_W-1:0] seed;
      send_idle_pct = idle_pct;
      stall_pct     = hold_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(39) == 0) begin
            case ($urandom_range(7))
               0:       seed = '0;
               1:       seed = '1;
               default: seed = random_word();
            endcase
            send_request(ACT_RESEED, seed);
         end else begin
            send_request(ACT_GENERATE, random_word());
         end
      end
   endtask

   // receiver holds off while numbers keep coming, so the request side backs up
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      long_hold_len = 300;
      -> hold_start;
      for (int i = 0; i < 60; i++) begin
         send_request(ACT_GENERATE, random_word());
      end
   endtask

   initial begin
      reseed_generator('0);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_boot_state();
      test_seed_extremes();
      test_mixed_traffic(330, 0, 0);
      test_mixed_traffic(330, 83, 0);
      test_mixed_traffic(330, 0, 83);
      test_mixed_traffic(330, 10, 10);
      test_output_backpressure();
      req_valid     <= 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      while (expected_numbers.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/xoro_pkg.sv
design/xoro_dp.sv
design/xoro_ctrl.sv
design/xoroshiro128_plus_prng.sv
tb/tb_xoroshiro128_plus_prng.sv
